### src/s20hs_pkg.sv
`default_nettype none

package s20hs_pkg;

  localparam int ROUNDS_DEF = 20;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_HI = 3'd5;

  localparam logic [63:0] CONST_LO_RST = 64'h3320646e_61707865;
  localparam logic [63:0] CONST_HI_RST = 64'h6b206574_79622d32;

  localparam logic [2:0] LAST_SALSA  = 3'd7;
  localparam logic [2:0] LAST_HSALSA = 3'd3;

  typedef struct packed {
    logic        req_type;
    logic [63:0] input_low;
    logic [63:0] input_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [1:0] {
    SS_IDLE,
    SS_ROUND,
    SS_OUT
  } ss_state_t;

endpackage

`default_nettype wire

### src/salsa20_hsalsa20_core.sv
// Channel | Ports                                     | Beat taken when
// --------+-------------------------------------------+--------------------------
// input   | start, busy, in_item                      | start & !busy
// result  | out_valid, out_item                       | every cycle out_valid is 1
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid & cfg_ready
//
// An item passes through a load, the ROUNDS rounds and then its result beats,
// eight in Salsa20 mode and four in HSalsa20 mode. The four column lanes do
// one add-rotate-xor step of their quarter rounds per cycle. Reset is
// synchronous and active low and restores the key to zero and the constant to
// its default. Result beats come on consecutive cycles and the receiver cannot
// stall them.
`default_nettype none

module salsa20_hsalsa20_core #(
  parameter int ROUNDS = s20hs_pkg::ROUNDS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire s20hs_pkg::in_item_t              in_item,
  output logic                                  out_valid,
  output s20hs_pkg::out_item_t                  out_item,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [s20hs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                      cfg_data
);

  localparam int RND_W = $clog2(ROUNDS);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  function automatic logic [3:0] ix(input int j, input int m);
    return 4'((5 * j + 4 * m) & 15);
  endfunction

  s20hs_pkg::ss_state_t state_r, state_nxt;
  logic [1:0]       step_r, step_nxt;
  logic [RND_W-1:0] round_r, round_nxt;
  logic [2:0]       widx_r, widx_nxt;
  logic             hmode_r, hmode_nxt;
  logic [31:0]      s_r [16];
  logic [31:0]      s_nxt [16];
  logic [31:0]      init_r [16];
  logic [31:0]      s_step [16];
  logic [31:0]      s_perm [16];
  logic [31:0]      s_load [16];
  logic [63:0]      key0_r, key1_r, key2_r, key3_r, clo_r, chi_r;
  logic             out_valid_r, out_valid_nxt;
  s20hs_pkg::out_item_t out_item_r, out_item_nxt;
  logic [63:0]      word_sel;
  logic [2:0]       last_idx;

  assign busy      = (state_r != s20hs_pkg::SS_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign last_idx  = hmode_r ? s20hs_pkg::LAST_HSALSA : s20hs_pkg::LAST_SALSA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      clo_r  <= s20hs_pkg::CONST_LO_RST;
      chi_r  <= s20hs_pkg::CONST_HI_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        s20hs_pkg::REG_KEY0:     key0_r <= cfg_data;
        s20hs_pkg::REG_KEY1:     key1_r <= cfg_data;
        s20hs_pkg::REG_KEY2:     key2_r <= cfg_data;
        s20hs_pkg::REG_KEY3:     key3_r <= cfg_data;
        s20hs_pkg::REG_CONST_LO: clo_r  <= cfg_data;
        s20hs_pkg::REG_CONST_HI: chi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_load[0]  = clo_r[31:0];
    s_load[5]  = clo_r[63:32];
    s_load[10] = chi_r[31:0];
    s_load[15] = chi_r[63:32];
    s_load[1]  = key0_r[31:0];
    s_load[2]  = key0_r[63:32];
    s_load[3]  = key1_r[31:0];
    s_load[4]  = key1_r[63:32];
    s_load[11] = key2_r[31:0];
    s_load[12] = key2_r[63:32];
    s_load[13] = key3_r[31:0];
    s_load[14] = key3_r[63:32];
    s_load[6]  = in_item.input_low[31:0];
    s_load[7]  = in_item.input_low[63:32];
    s_load[8]  = in_item.input_high[31:0];
    s_load[9]  = in_item.input_high[63:32];
  end

  always_comb begin
    logic [31:0] sum;
    sum = '0;
    s_step = s_r;
    for (int j = 0; j < 4; j++) begin
      unique case (step_r)
        2'd0: begin
          sum = s_r[ix(j, 0)] + s_r[ix(j, 3)];
          s_step[ix(j, 1)] = s_r[ix(j, 1)] ^ {sum[24:0], sum[31:25]};
        end
        2'd1: begin
          sum = s_r[ix(j, 1)] + s_r[ix(j, 0)];
          s_step[ix(j, 2)] = s_r[ix(j, 2)] ^ {sum[22:0], sum[31:23]};
        end
        2'd2: begin
          sum = s_r[ix(j, 2)] + s_r[ix(j, 1)];
          s_step[ix(j, 3)] = s_r[ix(j, 3)] ^ {sum[18:0], sum[31:19]};
        end
        2'd3: begin
          sum = s_r[ix(j, 3)] + s_r[ix(j, 2)];
          s_step[ix(j, 0)] = s_r[ix(j, 0)] ^ {sum[13:0], sum[31:14]};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int m = 0; m < 4; m++) begin
        s_perm[4'(4 * j + ((j + m) & 3))] = s_step[ix(j, m)];
      end
    end
  end

  always_comb begin
    word_sel = '0;
    if (hmode_r) begin
      unique case (widx_r[1:0])
        2'd0: word_sel = {s_r[5], s_r[0]};
        2'd1: word_sel = {s_r[15], s_r[10]};
        2'd2: word_sel = {s_r[7], s_r[6]};
        2'd3: word_sel = {s_r[9], s_r[8]};
        default: ;
      endcase
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (widx_r == 3'(i)) begin
          word_sel = {s_r[2 * i + 1] + init_r[2 * i + 1], s_r[2 * i] + init_r[2 * i]};
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      s20hs_pkg::SS_IDLE: begin
        if (start) state_nxt = s20hs_pkg::SS_ROUND;
      end
      s20hs_pkg::SS_ROUND: begin
        if (step_r == 2'd3 && round_r == RND_LAST) state_nxt = s20hs_pkg::SS_OUT;
      end
      s20hs_pkg::SS_OUT: begin
        if (widx_r == last_idx) state_nxt = s20hs_pkg::SS_IDLE;
      end
      default: state_nxt = s20hs_pkg::SS_IDLE;
    endcase
  end

  always_comb begin
    s_nxt         = s_r;
    step_nxt      = step_r;
    round_nxt     = round_r;
    widx_nxt      = widx_r;
    hmode_nxt     = hmode_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      s20hs_pkg::SS_IDLE: begin
        if (start) begin
          s_nxt     = s_load;
          hmode_nxt = in_item.req_type;
          step_nxt  = '0;
          round_nxt = '0;
          widx_nxt  = '0;
        end
      end
      s20hs_pkg::SS_ROUND: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          s_nxt     = s_perm;
          round_nxt = round_r + RND_W'(1);
        end else begin
          s_nxt = s_step;
        end
      end
      s20hs_pkg::SS_OUT: begin
        out_valid_nxt           = 1'b1;
        out_item_nxt.out_word   = word_sel;
        out_item_nxt.word_index = widx_r;
        out_item_nxt.last_word  = (widx_r == last_idx);
        widx_nxt                = widx_r + 3'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= s20hs_pkg::SS_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      round_r     <= '0;
      widx_r      <= '0;
      hmode_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      round_r     <= round_nxt;
      widx_r      <= widx_nxt;
      hmode_r     <= hmode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    out_item_r <= out_item_nxt;
    if (state_r == s20hs_pkg::SS_IDLE && start) begin
      init_r <= s_load;
    end
  end

endmodule

`default_nettype wire

### src/s20hs_chk.sv
`default_nettype none

module s20hs_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire s20hs_pkg::out_item_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not make the core busy");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_item.word_index == 3'd0)
    else $error("result burst did not open with index zero");

  a_burst_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_word |=>
      out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1)
    else $error("result burst broke or skipped an index");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_word |->
      (out_item.word_index == s20hs_pkg::LAST_SALSA ||
       out_item.word_index == s20hs_pkg::LAST_HSALSA))
    else $error("last beat at an unexpected index");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_word |=> !out_valid)
    else $error("result beat followed the last beat");

endmodule

bind salsa20_hsalsa20_core s20hs_chk u_s20hs_chk (.*);

`default_nettype wire
